FILE: hw/rtl/snsf_pkg.sv
// Shared constants, register codes and helpers for the nerve stimulation filter.
// No dependencies; used by snsf_mul, safe_nerve_stimulation_filter and tb_top.
package snsf_pkg;

   // Default parameter values
   localparam int SLEW_WIDTH_DEFAULT      = 24;
   localparam int ALPHA_FRAC_BITS_DEFAULT = 17;

   // Fixed field widths
   localparam int ALPHA_WIDTH     = 18;
   localparam int WEIGHT_WIDTH    = 24;
   localparam int LEVEL_WIDTH     = 24;
   localparam int LEVEL_FRAC_BITS = 16;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;

   // Shared multiplier slices the wide operand into chunks of this width
   localparam int MUL_CHUNK_WIDTH = 32;

   // Filter bank: filter one, magnitude filter, filter three
   localparam int FILTER_COUNT     = 3;
   localparam int FILTER_MAGNITUDE = 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ALPHA_SIGNED_ONE   = 3'd0,
      CSR_ALPHA_MAGNITUDE    = 3'd1,
      CSR_ALPHA_SIGNED_THREE = 3'd2,
      CSR_WEIGHT_ONE         = 3'd3,
      CSR_WEIGHT_TWO         = 3'd4,
      CSR_WEIGHT_THREE       = 3'd5
   } csr_index_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

FILE: hw/rtl/snsf_mul.sv
// Iterative unsigned multiplier: wide operand taken one chunk per cycle, MSB chunk first.
// Depends on snsf_pkg for the default chunk width.
module snsf_mul #(
   parameter int A_WIDTH     = 42,
   parameter int B_WIDTH     = 24,
   parameter int CHUNK_WIDTH = snsf_pkg::MUL_CHUNK_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [A_WIDTH-1:0]         op_a,
   input  logic [B_WIDTH-1:0]         op_b,
   output logic                       busy,
   output logic                       done,
   output logic [A_WIDTH+B_WIDTH-1:0] product
);
   localparam int NC   = (A_WIDTH + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
   localparam int PADW = NC * CHUNK_WIDTH;
   localparam int ACCW = PADW + B_WIDTH;
   localparam int PW   = A_WIDTH + B_WIDTH;
   localparam int CW   = $clog2(NC + 1);

   logic [PADW-1:0]              a_ff, a_in;
   logic [B_WIDTH-1:0]           b_ff, b_in;
   logic [ACCW-1:0]              acc_ff, acc_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CHUNK_WIDTH+B_WIDTH-1:0] part;

   // one chunk-by-b product per cycle
   assign part = a_ff[PADW-1 -: CHUNK_WIDTH] * b_ff;

   // next-state logic: load on start, then shift-accumulate
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = PADW'(op_a);
         b_in    = op_b;
         acc_in  = '0;
         cnt_in  = CW'(NC);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff << CHUNK_WIDTH) + ACCW'(part);
         a_in   = a_ff << CHUNK_WIDTH;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
         acc_ff  <= acc_in;
      end
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff[PW-1:0];

endmodule

FILE: hw/rtl/safe_nerve_stimulation_filter.sv
// Single-axis nerve stimulation estimator: three lowpass filters and weighted output sum.
// Depends on snsf_pkg and snsf_mul (one shared multiplier under a sequencer).
//
// Usage:
//   req_* carries one signed slew sample and a restart flag per transfer;
//   a transfer happens when req_valid is high and req_stall is low.
//   rsp_* returns one stimulation level (Q8.16, saturating) and a threshold
//   flag per sample, under the same valid/stall rule.
//   csr_* writes the three alphas and three weights; write only while idle.
//   Each sample is handled alone: req_stall stays high from the accepted
//   transfer until the result is loaded into the output register.
//   The shared chunked multiplier runs six products per sample (three filter
//   updates, three weighted terms), each on a wide operand of NC chunks,
//   with NC = ceil((SLEW_WIDTH + ALPHA_FRAC_BITS + 1) / 32).
//   A finished result sits in the output register; if the receiver stalls
//   and the next result is ready, the block waits before loading it.
//   Reset (synchronous) clears the filters, sets alphas to pass-through,
//   weights to zero, and drops rsp_valid.
module safe_nerve_stimulation_filter #(
   parameter int SLEW_WIDTH      = snsf_pkg::SLEW_WIDTH_DEFAULT,
   parameter int ALPHA_FRAC_BITS = snsf_pkg::ALPHA_FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SLEW_WIDTH-1:0]         req_slew_sample,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [snsf_pkg::LEVEL_WIDTH-1:0]     rsp_stim_level,
   output logic                                 rsp_over_threshold,
   input  logic                                 csr_write,
   input  logic [snsf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [snsf_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import snsf_pkg::*;

   // Widths
   localparam int YW        = SLEW_WIDTH + ALPHA_FRAC_BITS + 1;  // filter value
   localparam int DW        = YW + 1;                            // x<<F - y
   localparam int MA        = YW;                                // |d| and |y|
   localparam int AEW       = ALPHA_FRAC_BITS + 1;
   localparam int MB        = max_int(AEW, WEIGHT_WIDTH);
   localparam int PW        = MA + MB;
   localparam int PSW       = PW + 1;
   localparam int CAP_EXP   = ALPHA_FRAC_BITS + LEVEL_FRAC_BITS + LEVEL_WIDTH;
   localparam int SUMW      = CAP_EXP + 2;
   localparam int TERMW     = max_int(PW, SUMW);
   localparam int OUT_SHIFT = ALPHA_FRAC_BITS + LEVEL_FRAC_BITS;
   localparam int LEVW      = SUMW + 1 - OUT_SHIFT;
   localparam int ACMPW     = max_int(ALPHA_WIDTH, AEW);
   localparam int FIDX_W    = $clog2(FILTER_COUNT);

   localparam logic [FIDX_W-1:0]      FIDX_LAST   = FIDX_W'(FILTER_COUNT - 1);
   localparam logic [FIDX_W-1:0]      FIDX_MAG    = FIDX_W'(FILTER_MAGNITUDE);
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = (ALPHA_FRAC_BITS < ALPHA_WIDTH) ?
      ALPHA_WIDTH'(1 << ALPHA_FRAC_BITS) : {ALPHA_WIDTH{1'b1}};
   localparam logic [ACMPW-1:0]       ALPHA_ONE   = ACMPW'(1 << ALPHA_FRAC_BITS);
   localparam logic [TERMW-1:0]       TERM_CAP    = TERMW'(1) << CAP_EXP;
   localparam logic [SUMW:0]          ROUND_HALF  = (SUMW + 1)'(1) << (OUT_SHIFT - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIFF,
      S_FMUL,
      S_FWAIT,
      S_FUPD,
      S_TMUL,
      S_TWAIT,
      S_OUT
   } state_type;

   state_type                   state_ff, state_in;
   logic signed [SLEW_WIDTH-1:0] x_ff, x_in;
   logic [SLEW_WIDTH-1:0]        ax_ff, ax_in;
   logic signed [YW-1:0]         y_ff [FILTER_COUNT];
   logic signed [YW-1:0]         y_in [FILTER_COUNT];
   logic [FIDX_W-1:0]            fidx_ff, fidx_in;
   logic signed [DW-1:0]         d_ff, d_in;
   logic signed [PSW-1:0]        p_ff, p_in;
   logic [SUMW-1:0]              sum_ff, sum_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_WIDTH-1:0]       level_ff, level_in;
   logic                         over_ff, over_in;
   logic [ALPHA_WIDTH-1:0]       alpha_ff [FILTER_COUNT];
   logic [ALPHA_WIDTH-1:0]       alpha_in [FILTER_COUNT];
   logic [WEIGHT_WIDTH-1:0]      weight_ff [FILTER_COUNT];
   logic [WEIGHT_WIDTH-1:0]      weight_in [FILTER_COUNT];

   logic                         req_fire, rsp_fire, out_free;
   logic [SLEW_WIDTH-1:0]        slew_abs;
   logic signed [SLEW_WIDTH:0]   xk;
   logic signed [DW-1:0]         xk_ext, y_ext_d, d_calc, d_abs;
   logic signed [YW-1:0]         y_sel, y_new;
   logic [YW-1:0]                y_abs;
   logic [ACMPW-1:0]             alpha_sel, alpha_eff;
   logic                         mul_start, mul_busy, mul_done;
   logic [MA-1:0]                mul_a;
   logic [MB-1:0]                mul_b;
   logic [PW-1:0]                mul_product;
   logic signed [PSW-1:0]        prod_s, p_shift, round_ext, y_ext_p, y_sum;
   logic [TERMW-1:0]             prod_ext, term_capped;
   logic [SUMW:0]                rounded;
   logic [LEVW-1:0]              lev_wide;
   logic [LEVEL_WIDTH-1:0]       level_sat;

   // Handshakes
   assign req_stall = reset | (state_ff != S_IDLE);
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_fire  = rsp_valid_ff & ~rsp_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // Sample magnitude; the most negative slew maps to 2^(SLEW_WIDTH-1)
   assign slew_abs = req_slew_sample[SLEW_WIDTH-1] ?
                     SLEW_WIDTH'(-req_slew_sample) : req_slew_sample;

   // Filter input: magnitude filter takes |x|, the others take x
   assign xk      = (fidx_ff == FIDX_MAG) ? signed'({1'b0, ax_ff}) : (SLEW_WIDTH + 1)'(x_ff);
   assign y_sel   = y_ff[fidx_ff];
   assign xk_ext  = DW'(xk);
   assign y_ext_d = DW'(y_sel);
   assign d_calc  = (xk_ext <<< ALPHA_FRAC_BITS) - y_ext_d;
   assign d_abs   = d_ff[DW-1] ? -d_ff : d_ff;

   // Filter values stay between 0 and x<<F, so |y| fits without a cap
   assign y_abs = y_sel[YW-1] ? YW'(-y_sel) : YW'(y_sel);

   // Alpha above one acts as one
   assign alpha_sel = ACMPW'(alpha_ff[fidx_ff]);
   assign alpha_eff = (alpha_sel > ALPHA_ONE) ? ALPHA_ONE : alpha_sel;

   // Shared multiplier operands
   assign mul_start = (state_ff == S_FMUL) || (state_ff == S_TMUL);
   assign mul_a     = (state_ff == S_FMUL) ? d_abs[MA-1:0] : y_abs;
   assign mul_b     = (state_ff == S_FMUL) ? MB'(alpha_eff) : MB'(weight_ff[fidx_ff]);

   snsf_mul #(
      .A_WIDTH     (MA),
      .B_WIDTH     (MB),
      .CHUNK_WIDTH (MUL_CHUNK_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_product)
   );

   // Signed filter product and round-to-nearest update (floor of (p + half) >> F)
   assign prod_s    = signed'({1'b0, mul_product});
   assign p_shift   = p_ff >>> ALPHA_FRAC_BITS;
   assign round_ext = {{(PSW-1){1'b0}}, p_ff[ALPHA_FRAC_BITS-1]};
   assign y_ext_p   = PSW'(y_sel);
   assign y_sum     = y_ext_p + p_shift + round_ext;
   assign y_new     = y_sum[YW-1:0];

   // Weighted term, held to 2^CAP_EXP
   assign prod_ext    = TERMW'(mul_product);
   assign term_capped = (|prod_ext[TERMW-1:CAP_EXP]) ? TERM_CAP : prod_ext;

   // Output rounding and saturation
   assign rounded   = {1'b0, sum_ff} + ROUND_HALF;
   assign lev_wide  = rounded[SUMW:OUT_SHIFT];
   assign level_sat = (|lev_wide[LEVW-1:LEVEL_WIDTH]) ? {LEVEL_WIDTH{1'b1}} :
                      lev_wide[LEVEL_WIDTH-1:0];

   // Sequencer and configuration next-state logic
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      ax_in        = ax_ff;
      y_in         = y_ff;
      fidx_in      = fidx_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      sum_in       = sum_ff;
      level_in     = level_ff;
      over_in      = over_ff;
      alpha_in     = alpha_ff;
      weight_in    = weight_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_ALPHA_SIGNED_ONE:   alpha_in[0]  = csr_data[ALPHA_WIDTH-1:0];
            CSR_ALPHA_MAGNITUDE:    alpha_in[1]  = csr_data[ALPHA_WIDTH-1:0];
            CSR_ALPHA_SIGNED_THREE: alpha_in[2]  = csr_data[ALPHA_WIDTH-1:0];
            CSR_WEIGHT_ONE:         weight_in[0] = csr_data[WEIGHT_WIDTH-1:0];
            CSR_WEIGHT_TWO:         weight_in[1] = csr_data[WEIGHT_WIDTH-1:0];
            CSR_WEIGHT_THREE:       weight_in[2] = csr_data[WEIGHT_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               x_in    = req_slew_sample;
               ax_in   = slew_abs;
               fidx_in = '0;
               sum_in  = '0;
               if (req_restart) begin
                  for (int i = 0; i < FILTER_COUNT; i++) begin
                     y_in[i] = '0;
                  end
               end
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            d_in     = d_calc;
            state_in = S_FMUL;
         end
         S_FMUL: begin
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (mul_done) begin
               p_in     = d_ff[DW-1] ? -prod_s : prod_s;
               state_in = S_FUPD;
            end
         end
         S_FUPD: begin
            y_in[fidx_ff] = y_new;
            if (fidx_ff == FIDX_LAST) begin
               fidx_in  = '0;
               state_in = S_TMUL;
            end else begin
               fidx_in  = fidx_ff + FIDX_W'(1);
               state_in = S_DIFF;
            end
         end
         S_TMUL: begin
            state_in = S_TWAIT;
         end
         S_TWAIT: begin
            if (mul_done) begin
               sum_in = sum_ff + SUMW'(term_capped);
               if (fidx_ff == FIDX_LAST) begin
                  state_in = S_OUT;
               end else begin
                  fidx_in  = fidx_ff + FIDX_W'(1);
                  state_in = S_TMUL;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               level_in     = level_sat;
               over_in      = |level_sat[LEVEL_WIDTH-1:LEVEL_FRAC_BITS];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, filters, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FILTER_COUNT; i++) begin
            y_ff[i]      <= '0;
            alpha_ff[i]  <= ALPHA_RESET;
            weight_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         fidx_ff      <= fidx_in;
         rsp_valid_ff <= rsp_valid_in;
         y_ff         <= y_in;
         alpha_ff     <= alpha_in;
         weight_ff    <= weight_in;
         x_ff         <= x_in;
         ax_ff        <= ax_in;
         d_ff         <= d_in;
         p_ff         <= p_in;
         sum_ff       <= sum_in;
         level_ff     <= level_in;
         over_ff      <= over_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_stim_level     = level_ff;
   assign rsp_over_threshold = over_ff;

   // Checks
   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiplier started while busy");

   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_FWAIT || state_ff == S_TWAIT))
      else $error("multiplier result arrived outside a wait state");

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && state_ff != S_OUT) |=> !rsp_valid)
      else $error("result repeated after transfer");

   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_over_threshold ==
                     (rsp_stim_level[LEVEL_WIDTH-1:LEVEL_FRAC_BITS] != '0)))
      else $error("threshold flag disagrees with level");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second sample accepted while busy");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for safe_nerve_stimulation_filter: directed and random slew samples.
// Depends on snsf_pkg and the filter RTL; a scoreboard class predicts every stim level.
module tb_top;
   import snsf_pkg::*;

   localparam int SLEW_W = SLEW_WIDTH_DEFAULT;
   localparam int FRAC = ALPHA_FRAC_BITS_DEFAULT;
   localparam int OUT_SHIFT = FRAC + LEVEL_FRAC_BITS;
   localparam longint ALPHA_UNITY = longint'(1) << FRAC;
   localparam longint unsigned MAG_CAP = 64'd1 << (SLEW_W - 1 + FRAC);
   localparam longint unsigned TERM_CAP = 64'd1 << (OUT_SHIFT + LEVEL_WIDTH);
   localparam longint unsigned ROUND_HALF = 64'd1 << (OUT_SHIFT - 1);
   localparam longint unsigned LEVEL_MAX = (64'd1 << LEVEL_WIDTH) - 1;
   localparam longint unsigned LEVEL_UNITY = 64'd1 << LEVEL_FRAC_BITS;
   localparam logic signed [SLEW_W-1:0] SLEW_MAX = {1'b0, {(SLEW_W-1){1'b1}}};
   localparam logic signed [SLEW_W-1:0] SLEW_MIN = {1'b1, {(SLEW_W-1){1'b0}}};
   localparam logic [CSR_DATA_WIDTH-1:0] UNITY_WEIGHT = 24'h100000;  // 1.0 in Q4.20
   localparam logic [CSR_DATA_WIDTH-1:0] UNITY_ALPHA = CSR_DATA_WIDTH'(ALPHA_UNITY);
   localparam int TARGET_SAMPLES = 1900;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic                   flag;
   } stim_result_type;

   // Tracks filter state and settings, predicts each level and checks results in order
   class stim_scoreboard;
      logic [ALPHA_WIDTH-1:0]  alpha [FILTER_COUNT];
      logic [WEIGHT_WIDTH-1:0] weight [FILTER_COUNT];
      longint                  filt [FILTER_COUNT];
      stim_result_type         expected_levels [$];
      int unsigned             failures;

      function new();
         foreach (alpha[k]) begin
            alpha[k] = ALPHA_WIDTH'(ALPHA_UNITY);
            weight[k] = '0;
            filt[k] = 0;
         end
         failures = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            CSR_ALPHA_SIGNED_ONE:   alpha[0] = value[ALPHA_WIDTH-1:0];
            CSR_ALPHA_MAGNITUDE:    alpha[FILTER_MAGNITUDE] = value[ALPHA_WIDTH-1:0];
            CSR_ALPHA_SIGNED_THREE: alpha[2] = value[ALPHA_WIDTH-1:0];
            CSR_WEIGHT_ONE:         weight[0] = value[WEIGHT_WIDTH-1:0];
            CSR_WEIGHT_TWO:         weight[FILTER_MAGNITUDE] = value[WEIGHT_WIDTH-1:0];
            CSR_WEIGHT_THREE:       weight[2] = value[WEIGHT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // One lowpass step; alpha above one acts as pass-through, rounding ties go up
      function longint smooth(longint y, longint x, logic [ALPHA_WIDTH-1:0] a_reg);
         longint a, p;
         a = (a_reg > ALPHA_UNITY) ? ALPHA_UNITY : longint'(a_reg);
         p = ((x <<< FRAC) - y) * a;
         return y + ((p + (ALPHA_UNITY >>> 1)) >>> FRAC);
      endfunction

      // Weight times filter magnitude; the magnitude and the product are clamped
      function longint unsigned weighted(logic [WEIGHT_WIDTH-1:0] w, longint y);
         longint unsigned m, p;
         m = (y < 0) ? -y : y;
         if (m > MAG_CAP) m = MAG_CAP;
         p = w * m;
         return (p > TERM_CAP) ? TERM_CAP : p;
      endfunction

      function void note_sample(logic signed [SLEW_W-1:0] slew, logic restart);
         longint x, ax;
         longint unsigned total, lvl;
         stim_result_type want;
         x = longint'(slew);
         ax = (x < 0) ? -x : x;
         if (restart) begin
            foreach (filt[k]) filt[k] = 0;
         end
         filt[0] = smooth(filt[0], x, alpha[0]);
         filt[FILTER_MAGNITUDE] = smooth(filt[FILTER_MAGNITUDE], ax, alpha[FILTER_MAGNITUDE]);
         filt[2] = smooth(filt[2], x, alpha[2]);
         total = weighted(weight[0], filt[0]) + weighted(weight[FILTER_MAGNITUDE],
                 filt[FILTER_MAGNITUDE]) + weighted(weight[2], filt[2]);
         lvl = (total + ROUND_HALF) >> OUT_SHIFT;
         if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
         want.level = lvl[LEVEL_WIDTH-1:0];
         want.flag = (lvl >= LEVEL_UNITY);
         expected_levels.push_back(want);
      endfunction

      function void check_result(logic [LEVEL_WIDTH-1:0] level, logic flag);
         stim_result_type want;
         if (expected_levels.size() == 0) begin
            $error("unexpected result: stim_level %0d over_threshold %0d", level, flag);
            failures++;
            return;
         end
         want = expected_levels.pop_front();
         if (level !== want.level) begin
            $error("stim_level: expected %0d, got %0d", want.level, level);
            failures++;
         end
         if (flag !== want.flag) begin
            $error("over_threshold: expected %0d, got %0d", want.flag, flag);
            failures++;
         end
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SLEW_W-1:0] req_slew_sample = '0;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [LEVEL_WIDTH-1:0] rsp_stim_level;
   logic rsp_over_threshold;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   stim_scoreboard sb = new();
   bit source_steady = 1'b0;
   bit sink_steady = 1'b0;
   int samples_sent = 0;

   safe_nerve_stimulation_filter i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_slew_sample    (req_slew_sample),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stim_level     (rsp_stim_level),
      .rsp_over_threshold (rsp_over_threshold),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #10 clock = ~clock;

   // Watchdog
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("safe_nerve_stimulation_filter regression: fail");
      $finish;
   end

   // Result side: check each transfer, then, unless the sink is steady, stall for a random number of cycles
   initial begin : result_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            sb.check_result(rsp_stim_level, rsp_over_threshold);
            hold = sink_steady ? 0 : $urandom_range(0, 17);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   // Present one sample after a random gap (none when the source is steady) and hold it until the transfer
   task automatic send_sample(input logic signed [SLEW_W-1:0] slew, input logic restart);
      int gap;
      gap = source_steady ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_slew_sample <= slew;
      req_restart <= restart;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_sample(slew, restart);
      samples_sent++;
   endtask

   // Drop valid, then wait on the clock until every result is back
   task automatic await_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Write all six registers back to back
   task automatic program_filter(input logic [CSR_DATA_WIDTH-1:0] a1, a2, a3, w1, w2, w3);
      csr_index_type order [6];
      logic [CSR_DATA_WIDTH-1:0] value [6];
      order = '{CSR_ALPHA_SIGNED_ONE, CSR_ALPHA_MAGNITUDE, CSR_ALPHA_SIGNED_THREE,
                CSR_WEIGHT_ONE, CSR_WEIGHT_TWO, CSR_WEIGHT_THREE};
      value = '{a1, a2, a3, w1, w2, w3};
      foreach (order[k]) begin
         csr_write <= 1'b1;
         csr_index <= order[k];
         csr_data <= value[k];
         @(posedge clock);
         sb.set_register(order[k], value[k]);
      end
      csr_write <= 1'b0;
   endtask

   function automatic logic signed [SLEW_W-1:0] draw_slew();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return SLEW_W'($urandom());
         5, 6, 7: return SLEW_W'($urandom_range(0, 16383) - 8192);
         8: return SLEW_W'($urandom_range(0, 131071) - 65536);
         default: begin
            case ($urandom_range(0, 4))
               0: return SLEW_MAX;
               1: return SLEW_MIN;
               2: return SLEW_W'(1);
               3: return SLEW_W'(-1);
               default: return '0;
            endcase
         end
      endcase
   endfunction

   // Alphas: zero, unity, above unity, fractional, tiny, raw data with upper bits
   function automatic logic [CSR_DATA_WIDTH-1:0] draw_alpha();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return UNITY_ALPHA;
         2: return CSR_DATA_WIDTH'($urandom_range(32'(ALPHA_UNITY + 1),
                                                  (1 << ALPHA_WIDTH) - 1));
         3: return CSR_DATA_WIDTH'($urandom_range(1, 32'(ALPHA_UNITY - 1)));
         4: return CSR_DATA_WIDTH'($urandom_range(1, 255));
         default: return CSR_DATA_WIDTH'($urandom());
      endcase
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] draw_weight();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return CSR_DATA_WIDTH'($urandom());
         3: return CSR_DATA_WIDTH'($urandom_range(0, 2 * UNITY_WEIGHT));
         default: return CSR_DATA_WIDTH'($urandom_range(1, 8192));
      endcase
   endfunction

   initial begin : stimulus
      int burst;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: zero weights give a zero level
      send_sample(12345, 1'b0);
      send_sample(SLEW_MIN, 1'b1);

      // Pass-through on filter one at unit weight: threshold edge, extremes, saturation;
      // the other alphas sit above one, one of them written with upper data bits set
      await_idle();
      program_filter(UNITY_ALPHA, '1, UNITY_ALPHA + 1'b1, UNITY_WEIGHT, '0, '0);
      send_sample(4095, 1'b1);
      send_sample(4096, 1'b0);
      send_sample(-4096, 1'b0);
      send_sample(-4095, 1'b0);
      send_sample(0, 1'b0);
      send_sample(SLEW_MAX, 1'b0);
      send_sample(SLEW_MIN, 1'b0);
      send_sample(1, 1'b0);
      send_sample(-1, 1'b0);

      // Frozen filter one with max weight, half-step magnitude filter, restarts
      await_idle();
      program_filter('0, UNITY_ALPHA >> 1, 1, '1, UNITY_WEIGHT, '1);
      send_sample(SLEW_MIN, 1'b1);
      send_sample(SLEW_MAX, 1'b0);
      send_sample(SLEW_MAX, 1'b0);
      send_sample(-300000, 1'b0);
      send_sample(0, 1'b1);
      send_sample(SLEW_MIN, 1'b0);
      send_sample(1000, 1'b1);
      send_sample(-1000, 1'b0);

      // Random phases, each with fresh settings and idling style
      while (samples_sent < TARGET_SAMPLES) begin
         await_idle();
         program_filter(draw_alpha(), draw_alpha(), draw_alpha(),
                        draw_weight(), draw_weight(), draw_weight());
         source_steady = ($urandom_range(0, 3) == 0);
         sink_steady = ($urandom_range(0, 3) == 0);
         burst = $urandom_range(150, 300);
         repeat (burst) begin
            send_sample(draw_slew(), $urandom_range(0, 15) == 0);
            if ($urandom_range(0, 199) == 0) await_idle();
         end
      end

      await_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("safe_nerve_stimulation_filter regression: pass");
      else
         $display("safe_nerve_stimulation_filter regression: fail");
      $finish;
   end
endmodule
